/* rtl/trix_pkg.sv */
// ----------------------------------------------------------------------------
// TRIX package
// Shared widths and constants for the TRIX oscillator.
// ----------------------------------------------------------------------------
package trix_pkg;
  localparam int MaxWindow   = 200;
  localparam int EmaWidth    = 48;
  localparam int SumWidth    = 56;
  localparam int NumWidth    = 64;
  localparam int DenWidth    = 48;
  localparam logic [7:0] ResetWindow = 8'd15;
endpackage

/* rtl/trix_stream_if.sv */
// ----------------------------------------------------------------------------
// TRIX stream interfaces
// Valid/ready channels for price requests and rate results.
// ----------------------------------------------------------------------------
interface trix_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] close_price;
  logic [31:0] bar_time;
  modport source(output valid, close_price, bar_time, input ready);
  modport sink(input valid, close_price, bar_time, output ready);
endinterface

interface trix_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] trix_percent;
  logic [31:0] out_time;
  logic        div_zero;
  modport source(output valid, trix_percent, out_time, div_zero, input ready);
  modport sink(input valid, trix_percent, out_time, div_zero, output ready);
endinterface

/* rtl/trix_divider.sv */
// ----------------------------------------------------------------------------
// TRIX divider
// Restoring divider, one quotient bit per cycle, 64-bit numerator.
// ----------------------------------------------------------------------------
module trix_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [trix_pkg::NumWidth-1:0]     num,
  input  logic [trix_pkg::DenWidth-1:0]     den,
  output logic                              done,
  output logic [trix_pkg::NumWidth-1:0]     quo,
  output logic [trix_pkg::DenWidth-1:0]     rem
);
  import trix_pkg::*;

  logic [NumWidth-1:0] q;
  logic [DenWidth:0]   r;
  logic [DenWidth-1:0] d;
  logic [6:0]          cnt;
  logic                busy;
  logic [DenWidth:0]   shifted;
  logic [DenWidth:0]   diff;

  assign shifted = {r[DenWidth-1:0], q[NumWidth-1]};
  assign diff    = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'(NumWidth);
        q    <= num;
        r    <= '0;
        d    <= den;
      end else if (busy) begin
        if (!diff[DenWidth]) begin
          r <= diff;
          q <= {q[NumWidth-2:0], 1'b1};
        end else begin
          r <= shifted;
          q <= {q[NumWidth-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
  assign rem = r[DenWidth-1:0];
endmodule

/* rtl/trix_triple_ema_rate.sv */
// ----------------------------------------------------------------------------
// TRIX triple EMA rate
// Three cascaded EMA stages and a percent rate, on one shared divider.
//
//   channel  direction  content
//   in_ch    sink       close_price, bar_time
//   out_ch   source     trix_percent, out_time, div_zero
//   cfg      write      average_size (clears all state)
//
// A request that only adds to a seed sum returns to idle without a division. Each
// stage that divides uses the shared restoring divider, and a rate with a nonzero
// prior value adds two more divisions, one for the integer part, one for the fraction.
// Reset and any configuration write clear all stage state.
// A waiting result holds the block until it is taken.
// ----------------------------------------------------------------------------
module trix_triple_ema_rate (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  trix_in_if.sink    in_ch,
  trix_out_if.source out_ch
);
  import trix_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STAGE = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_WAIT  = 4'd3;
  localparam logic [3:0] S_RATE  = 4'd4;
  localparam logic [3:0] S_Q1    = 4'd5;
  localparam logic [3:0] S_Q2    = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0] state;
  logic [7:0] avg;
  logic [7:0] n;
  logic [1:0] stg;
  logic [7:0] cnt [3];
  logic [SumWidth-1:0] sum [3];
  logic [EmaWidth-1:0] ema [3];
  logic [EmaWidth-1:0] x;
  logic [EmaWidth-1:0] old3;
  logic [1:0] fcount;
  logic [31:0] time_r;
  logic neg;
  logic [EmaWidth-1:0] diffm;
  logic [NumWidth-1:0] prod;
  logic [15:0] q1;
  logic [31:0] res;
  logic dz;
  logic ovf;
  logic [32:0] mag;

  logic div_start, div_done;
  logic [NumWidth-1:0] div_num, div_quo;
  logic [DenWidth-1:0] div_den, div_rem;

  trix_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  assign n = (avg == 8'd0) ? 8'd1 : ((avg > 8'(MaxWindow)) ? 8'(MaxWindow) : avg);
  assign in_ch.ready = (state == S_IDLE) && !cfg_we;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.trix_percent = res;
  assign out_ch.out_time = time_r;
  assign out_ch.div_zero = dz;

  logic [SumWidth-1:0] sum_next;
  logic [EmaWidth-1:0] seed_x;
  assign seed_x = (stg == 2'd0) ? {16'd0, x[47:16]} : x;
  assign sum_next = sum[stg] + SumWidth'(seed_x);
  assign mag = {1'b0, q1, 16'd0} + 33'(div_quo);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_IDLE;
      div_start <= 1'b0;
      fcount <= '0;
      for (int i = 0; i < 3; i++) begin
        cnt[i] <= '0;
        sum[i] <= '0;
        ema[i] <= '0;
      end
      if (rst) avg <= ResetWindow;
      else avg <= cfg_data;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            x <= {in_ch.close_price, 16'd0};
            time_r <= in_ch.bar_time;
            stg <= 2'd0;
            old3 <= ema[2];
            state <= S_STAGE;
          end
        end
        S_STAGE: begin
          if (cnt[stg] < n) begin
            sum[stg] <= sum_next;
            cnt[stg] <= cnt[stg] + 8'd1;
            if (cnt[stg] + 8'd1 < n) begin
              state <= S_IDLE;
            end else begin
              div_num <= (stg == 2'd0) ? {sum_next[47:0], 16'd0} : NumWidth'(sum_next);
              div_den <= DenWidth'(n);
              div_start <= 1'b1;
              state <= S_WAIT;
            end
          end else begin
            prod <= ema[stg] * (n - 8'd1);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          div_num <= prod + {15'd0, x, 1'b0};
          div_den <= DenWidth'({1'b0, n} + 9'd1);
          div_start <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            ema[stg] <= div_quo[EmaWidth-1:0];
            x <= div_quo[EmaWidth-1:0];
            if (stg != 2'd2) begin
              stg <= stg + 2'd1;
              state <= S_STAGE;
            end else if (fcount == 2'd0) begin
              fcount <= 2'd1;
              state <= S_IDLE;
            end else begin
              fcount <= 2'd2;
              state <= S_RATE;
            end
          end
        end
        S_RATE: begin
          neg <= x < old3;
          diffm <= (x < old3) ? old3 - x : x - old3;
          if (old3 == '0) begin
            res <= '0;
            dz <= 1'b1;
            state <= S_OUT;
          end else begin
            dz <= 1'b0;
            state <= S_Q1;
            prod <= '0;
          end
        end
        S_Q1: begin
          if (prod == '0 && !div_start) begin
            div_num <= 64'(diffm) * 64'd100;
            div_den <= old3;
            div_start <= 1'b1;
            prod <= 64'd1;
          end else if (div_done) begin
            ovf <= div_quo >= 64'h8000;
            q1 <= div_quo[15:0];
            div_num <= {div_rem, 16'd0};
            div_den <= old3;
            div_start <= 1'b1;
            state <= S_Q2;
          end
        end
        S_Q2: begin
          if (div_done) begin
            if (ovf) begin
              res <= neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
              if (neg) res <= (mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - mag);
              else res <= (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// TRIX triple EMA rate testbench
// Drives price requests through the valid/ready channels, predicts every rate
// result from its own model of the three EMA stages and compares each result
// field by field. The window is changed between phases, only when idle.
// ----------------------------------------------------------------------------
class trix_scoreboard;
  typedef struct packed {
    logic [31:0] pct;
    logic [31:0] tm;
    logic        dz;
  } rate_t;

  rate_t       pending[$];
  int          errors;
  logic [7:0]  window;
  logic [63:0] cnt1, sum1, ema1, cnt2, sum2, ema2, cnt3, sum3, ema3;
  logic [63:0] prior3;
  int          ema3_seen;

  function new();
    errors = 0;
    configure(trix_pkg::ResetWindow);
  endfunction

  function void configure(logic [7:0] v);
    window = v;
    cnt1 = 0; sum1 = 0; ema1 = 0;
    cnt2 = 0; sum2 = 0; ema2 = 0;
    cnt3 = 0; sum3 = 0; ema3 = 0;
    prior3 = 0;
    ema3_seen = 0;
  endfunction

  function bit ema_step(logic [63:0] n, logic [63:0] x, logic [63:0] seed_x, int shift,
                        inout logic [63:0] cnt, inout logic [63:0] sum,
                        inout logic [63:0] ema);
    if (cnt < n) begin
      sum = sum + seed_x;
      cnt = cnt + 1;
      if (cnt < n) return 0;
      ema = ((sum << shift) / n) & 64'h0000_FFFF_FFFF_FFFF;
      return 1;
    end
    ema = ((ema * (n - 1) + 2 * x) / (n + 1)) & 64'h0000_FFFF_FFFF_FFFF;
    return 1;
  endfunction

  function logic [31:0] rate_of(logic [63:0] now, logic [63:0] prev);
    logic        neg;
    logic [63:0] d, q, r, mag;
    neg = now < prev;
    d = neg ? prev - now : now - prev;
    q = (d * 100) / prev;
    r = (d * 100) % prev;
    if (q >= 64'h8000) mag = 64'h8000_0000;
    else mag = (q << 16) + ((r << 16) / prev);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function void note_request(logic [31:0] price, logic [31:0] bar_time);
    logic [63:0] n, old3;
    rate_t       res;
    n = (window == 0) ? 1 : (window > trix_pkg::MaxWindow) ? trix_pkg::MaxWindow : window;
    if (!ema_step(n, {16'd0, price, 16'd0}, {32'd0, price}, 16, cnt1, sum1, ema1)) return;
    if (!ema_step(n, ema1, ema1, 0, cnt2, sum2, ema2)) return;
    old3 = ema3;
    if (!ema_step(n, ema2, ema2, 0, cnt3, sum3, ema3)) return;
    if (ema3_seen == 0) begin
      ema3_seen = 1;
      return;
    end
    prior3 = old3;
    res.tm = bar_time;
    if (prior3 == 0) begin
      res.pct = 0;
      res.dz = 1;
    end else begin
      res.pct = rate_of(ema3, prior3);
      res.dz = 0;
    end
    pending.insert(pending.size(), res);
  endfunction

  function void check_rate(logic [31:0] pct, logic [31:0] tm, logic dz);
    rate_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result pct=%h time=%h dz=%b", $time, pct, tm, dz);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (pct !== exp_r.pct) begin
      $display("%0t: trix_percent expected %h actual %h", $time, exp_r.pct, pct);
      errors++;
    end
    if (tm !== exp_r.tm) begin
      $display("%0t: out_time expected %h actual %h", $time, exp_r.tm, tm);
      errors++;
    end
    if (dz !== exp_r.dz) begin
      $display("%0t: div_zero expected %b actual %b", $time, exp_r.dz, dz);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_we = 0;
  logic [7:0] cfg_data = 0;
  logic       quiet = 0;
  logic       hold_req = 0;
  logic       holding = 0;
  logic [31:0] walk_price = 32'h0064_0000;
  int          sent = 0;

  trix_in_if  in_bus();
  trix_out_if out_bus();
  trix_scoreboard sb = new();

  trix_triple_ema_rate uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_bus), .out_ch(out_bus)
  );

  initial begin
    in_bus.valid = 0;
    in_bus.close_price = 0;
    in_bus.bar_time = 0;
    out_bus.ready = 0;
  end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && in_bus.valid && in_bus.ready) sb.note_request(in_bus.close_price, in_bus.bar_time);
    if (!rst && out_bus.valid && out_bus.ready)
      sb.check_rate(out_bus.trix_percent, out_bus.out_time, out_bus.div_zero);
  end

  always @(posedge clk) begin
    if (holding) out_bus.ready <= 0;
    else out_bus.ready <= quiet || ($urandom_range(99) >= 24);
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    holding <= 1;
    repeat (4000) @(posedge clk);
    holding <= 0;
  end

  task automatic send_request(logic [31:0] price, logic [31:0] tm);
    if (!quiet && $urandom_range(99) < 24) begin
      in_bus.valid <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_bus.valid <= 1;
    in_bus.close_price <= price;
    in_bus.bar_time <= tm;
    do @(posedge clk); while (!in_bus.ready);
    sent++;
  endtask

  task automatic drain();
    in_bus.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_window(logic [7:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.configure(v);
  endtask

  function automatic logic [31:0] pick_price();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return 0;
    if (sel < 28) return $urandom();
    walk_price = walk_price + $urandom_range(8192) - 4096;
    return walk_price;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_request(pick_price(), $urandom());
  endtask

  logic [31:0] directed[20] = '{
    32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0, 32'h0000_0001, 32'h0000_0002, 32'h0001_0000,
    32'h0001_0001, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h0, 32'h1234_5678,
    32'h1234_5679, 32'h1234_5677, 32'hFFFF_FFFF
  };
  logic [7:0] windows[6] = '{8'd0, 8'd2, 8'd3, 8'd255, 8'd200, 8'd4};
  int counts[6] = '{150, 200, 200, 650, 30, 150};

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    random_phase(80);
    write_window(8'd1);
    foreach (directed[i]) send_request(directed[i], (i % 2) ? 32'hFFFF_FFFF : 32'h0);
    foreach (windows[i]) begin
      write_window(windows[i]);
      if (i == 1) hold_req <= 1;
      if (i == 2) quiet <= 1;
      random_phase(counts[i]);
      quiet <= 0;
    end
    while (sent < 1950) begin
      write_window(8'($urandom_range(12, 1)));
      random_phase(150);
    end
    drain();
    if (sb.errors == 0) $display("PASS trix_triple_ema_rate");
    else $display("FAIL trix_triple_ema_rate");
    $finish;
  end

  initial begin
    #60ms;
    $display("FAIL trix_triple_ema_rate");
    $finish;
  end
endmodule
